FILE: rtl/ibq_pkg.sv
// Shared types and constants for the inverse-resonance biquad axis.
package ibq_pkg;

    localparam int HIST_BITS  = 64;
    localparam int DIGIT_BITS = 8;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_ENABLE = 3'd5,
        REG_ACTIVE = 3'd6
    } cfg_reg_t;

    typedef logic signed [HIST_BITS-1:0] hist_t;

    localparam hist_t HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
    localparam hist_t HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};

    // Request to the shared multiplier: start pulse, and full selects the
    // 64-bit operand with fraction rounding instead of the short sample operand.
    typedef struct packed {
        logic start;
        logic full;
    } mul_ctl_t;

endpackage

FILE: rtl/ibq_mul.sv
// Digit-serial signed multiplier with rounding and 64-bit saturation.
module ibq_mul #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 48,
    parameter int COEF_FRAC_BITS = 36
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ibq_pkg::mul_ctl_t           ctl,
    input  logic signed [COEF_BITS-1:0] coef,
    input  ibq_pkg::hist_t              opnd,
    output logic                        done,
    output ibq_pkg::hist_t              prod
);
    import ibq_pkg::*;

    localparam int FULL_STEPS  = HIST_BITS / DIGIT_BITS;
    localparam int SHORT_STEPS = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int SHORT_W     = SHORT_STEPS * DIGIT_BITS;
    localparam int PW          = COEF_BITS + HIST_BITS;
    localparam int SW          = COEF_BITS + DIGIT_BITS;
    localparam int CNT_W       = $clog2(FULL_STEPS + 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_POST = 3'b100
    } mstate_t;

    mstate_t              st_reg, st_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [COEF_BITS-1:0] mc_reg;
    logic [HIST_BITS-1:0] lm_reg;
    logic [COEF_BITS-1:0] acc_reg;
    logic                 neg_reg;
    logic                 full_reg;
    logic                 done_reg;
    hist_t                prod_reg;

    logic [COEF_BITS-1:0] coef_mag;
    logic [HIST_BITS-1:0] opnd_mag;
    logic [SW-1:0]        step_pp;
    logic [SW-1:0]        step_sum;
    logic [PW-1:0]        p_full;
    logic [PW-1:0]        p_short;
    logic [PW-1:0]        p_tr;
    logic [HIST_BITS-1:0] p_lo;
    logic [HIST_BITS-1:0] p_val;
    logic                 rbit;
    logic                 hi_any;
    logic                 pos_ovf;
    logic                 neg_ovf;
    hist_t                p_res;

    assign coef_mag = coef[COEF_BITS-1] ? (~$unsigned(coef) + COEF_BITS'(1)) : $unsigned(coef);
    assign opnd_mag = opnd[HIST_BITS-1] ? (~$unsigned(opnd) + HIST_BITS'(1)) : $unsigned(opnd);

    // One digit of the serial operand times the parallel magnitude per cycle.
    assign step_pp  = mc_reg * lm_reg[DIGIT_BITS-1:0];
    assign step_sum = SW'(acc_reg) + step_pp;

    // Low product digits collect at the top of lm_reg as the operand shifts out.
    assign p_full  = {acc_reg, lm_reg};
    assign p_short = PW'({acc_reg, lm_reg[HIST_BITS-1 -: SHORT_W]});
    assign p_tr    = full_reg ? (p_full >> COEF_FRAC_BITS) : p_short;
    assign rbit    = full_reg & p_full[COEF_FRAC_BITS-1];
    assign hi_any  = |p_tr[PW-1:HIST_BITS];
    assign p_lo    = p_tr[HIST_BITS-1:0];
    assign pos_ovf = hi_any | p_lo[HIST_BITS-1] | ((&p_lo[HIST_BITS-2:0]) & rbit);
    assign neg_ovf = hi_any | (p_lo[HIST_BITS-1] & ((|p_lo[HIST_BITS-2:0]) | rbit));

    // Negate with the rounding increment folded in: -(m + r) = ~m + (1 - r).
    assign p_val = neg_reg ? (~p_lo + {{(HIST_BITS-1){1'b0}}, ~rbit})
                           : (p_lo + {{(HIST_BITS-1){1'b0}}, rbit});

    always_comb begin
        if (neg_reg) begin
            p_res = neg_ovf ? HIST_MIN : hist_t'(p_val);
        end else begin
            p_res = pos_ovf ? HIST_MAX : hist_t'(p_val);
        end
    end

    always_comb begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        unique case (st_reg)
            M_IDLE: begin
                if (ctl.start) begin
                    st_next  = M_RUN;
                    cnt_next = ctl.full ? CNT_W'(FULL_STEPS) : CNT_W'(SHORT_STEPS);
                end
            end
            M_RUN: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    st_next = M_POST;
                end
            end
            M_POST: begin
                st_next = M_IDLE;
            end
            default: begin
                st_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= M_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= (st_reg == M_POST);
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == M_IDLE && ctl.start) begin
            mc_reg   <= coef_mag;
            lm_reg   <= opnd_mag;
            acc_reg  <= '0;
            neg_reg  <= coef[COEF_BITS-1] ^ opnd[HIST_BITS-1];
            full_reg <= ctl.full;
        end else if (st_reg == M_RUN) begin
            acc_reg <= step_sum[SW-1:DIGIT_BITS];
            lm_reg  <= {step_sum[DIGIT_BITS-1:0], lm_reg[HIST_BITS-1:DIGIT_BITS]};
        end
        if (st_reg == M_POST) begin
            prod_reg <= p_res;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> (st_reg == M_IDLE))
        else $error("multiplier request while busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("multiplier done held longer than one cycle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == M_RUN) |-> (cnt_reg != '0))
        else $error("multiplier running with no digits left");

endmodule

FILE: rtl/inverse_resonance_biquad_axis.sv
// One axis of a galvo pre-compensation filter: a transposed direct form II
// biquad with signed fixed-point coefficients and 64-bit history. A filtered
// sample is finished before the next one is accepted: the five products run
// in turn on one multiplier that consumes 8 operand bits per cycle, two digits
// at the default widths for each sample product and eight for each product
// with the output, and each product passes through the request register and
// the multiplier's post state and done register. With global_enable or
// axis_active low the sample passes unchanged to the output. A finished result
// waits in the output register while the next sample is accepted. The input
// clear flag and any write to a defined register zero the history.
module inverse_resonance_biquad_axis #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 48,
    parameter int COEF_FRAC_BITS = 36
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // sample_in, clear_history, zero pad
    input  logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0]  s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // sample_out, saturated, zero pad
    output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0]  m_tdata,
    input  logic                                      cfg_wr_en,
    input  logic [ibq_pkg::CFG_ADDR_W-1:0]            cfg_addr,
    input  logic [COEF_BITS-1:0]                      cfg_wr_data
);
    import ibq_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int MAG_W   = HIST_BITS + 1 - COEF_FRAC_BITS;
    localparam int RW      = (MAG_W > SAMPLE_BITS + 1) ? MAG_W : SAMPLE_BITS + 1;

    localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;
    localparam logic [HIST_BITS:0] RND_HALF = (HIST_BITS + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_B0   = 9'b000000010,
        ST_A1   = 9'b000000100,
        ST_B1   = 9'b000001000,
        ST_H1   = 9'b000010000,
        ST_A2   = 9'b000100000,
        ST_B2   = 9'b001000000,
        ST_RND  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic                         kick_reg, kick_next;
    logic signed [COEF_BITS-1:0]  coef_b0_reg;
    logic signed [COEF_BITS-1:0]  coef_b1_reg;
    logic signed [COEF_BITS-1:0]  coef_b2_reg;
    logic signed [COEF_BITS-1:0]  coef_a1_reg;
    logic signed [COEF_BITS-1:0]  coef_a2_reg;
    logic                         enable_reg;
    logic                         active_reg;
    hist_t                        h1_reg;
    hist_t                        h2_reg;
    hist_t                        y_reg;
    hist_t                        tmp_reg;
    logic [SAMPLE_BITS-1:0]       x_reg;
    logic [SAMPLE_BITS-1:0]       res_reg;
    logic                         res_sat_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]           m_tdata_reg;

    logic                         s_acc;
    logic                         s_clear;
    logic                         filter_on;
    logic                         out_free;
    logic                         cfg_hit;
    mul_ctl_t                     mul_ctl;
    logic signed [COEF_BITS-1:0]  mul_coef;
    hist_t                        mul_opnd;
    hist_t                        x_ext;
    logic                         mul_done;
    hist_t                        mul_prod;
    hist_t                        alu_a;
    hist_t                        alu_b;
    logic                         alu_sub;
    hist_t                        alu_out;
    logic [HIST_BITS:0]           rnd_sum;
    logic [RW-1:0]                rnd_mag;
    logic [SAMPLE_BITS-1:0]       mag_lo;
    logic                         rnd_neg;
    logic                         pos_clip;
    logic                         neg_clip;
    logic [SAMPLE_BITS-1:0]       rnd_val;
    logic                         rnd_clip;

    // Exact sum or difference, clamped to the 64-bit range.
    function automatic hist_t sat_sum(hist_t a, hist_t b, logic sub);
        logic [HIST_BITS:0] s;
        if (sub) begin
            s = {a[HIST_BITS-1], a} - {b[HIST_BITS-1], b};
        end else begin
            s = {a[HIST_BITS-1], a} + {b[HIST_BITS-1], b};
        end
        if (s[HIST_BITS] != s[HIST_BITS-1]) begin
            return s[HIST_BITS] ? HIST_MIN : HIST_MAX;
        end
        return hist_t'(s[HIST_BITS-1:0]);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid & s_tready;
    assign s_clear   = s_tdata[SAMPLE_BITS];
    assign filter_on = enable_reg & active_reg;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign x_ext     = {{(HIST_BITS-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};

    always_comb begin
        cfg_hit = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_addr) inside
                REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_ENABLE, REG_ACTIVE: begin
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Operands for the shared multiplier, sampled on the request cycle.
    always_comb begin
        mul_ctl.start = kick_reg;
        mul_ctl.full  = 1'b0;
        mul_coef      = coef_b0_reg;
        mul_opnd      = x_ext;
        case (state_reg)
            ST_A1: begin
                mul_coef     = coef_a1_reg;
                mul_opnd     = y_reg;
                mul_ctl.full = 1'b1;
            end
            ST_B1: begin
                mul_coef = coef_b1_reg;
            end
            ST_A2: begin
                mul_coef     = coef_a2_reg;
                mul_opnd     = y_reg;
                mul_ctl.full = 1'b1;
            end
            ST_B2: begin
                mul_coef = coef_b2_reg;
            end
            default: begin
                mul_coef = coef_b0_reg;
            end
        endcase
    end

    ibq_mul #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COEF_BITS     (COEF_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (mul_ctl),
        .coef   (mul_coef),
        .opnd   (mul_opnd),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    always_comb begin
        alu_a   = mul_prod;
        alu_b   = h1_reg;
        alu_sub = 1'b0;
        case (state_reg)
            ST_B1: begin
                alu_b   = tmp_reg;
                alu_sub = 1'b1;
            end
            ST_H1: begin
                alu_a = tmp_reg;
                alu_b = h2_reg;
            end
            ST_B2: begin
                alu_b   = tmp_reg;
                alu_sub = 1'b1;
            end
            default: begin
                alu_b = h1_reg;
            end
        endcase
        alu_out = sat_sum(alu_a, alu_b, alu_sub);
    end

    // Round y to an integer on its magnitude: half + |y| either way.
    assign rnd_neg  = y_reg[HIST_BITS-1];
    assign rnd_sum  = rnd_neg ? (RND_HALF - {y_reg[HIST_BITS-1], y_reg})
                              : ({1'b0, y_reg} + RND_HALF);
    assign rnd_mag  = RW'(rnd_sum >> COEF_FRAC_BITS);
    assign mag_lo   = rnd_mag[SAMPLE_BITS-1:0];
    assign pos_clip = |rnd_mag[RW-1:SAMPLE_BITS-1];
    assign neg_clip = (|rnd_mag[RW-1:SAMPLE_BITS])
                    | (rnd_mag[SAMPLE_BITS-1] & (|rnd_mag[SAMPLE_BITS-2:0]));
    assign rnd_clip = rnd_neg ? neg_clip : pos_clip;

    always_comb begin
        if (rnd_neg) begin
            rnd_val = neg_clip ? SMIN : (~mag_lo + SAMPLE_BITS'(1));
        end else begin
            rnd_val = pos_clip ? SMAX : mag_lo;
        end
    end

    always_comb begin
        state_next = state_reg;
        kick_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (filter_on) begin
                        state_next = ST_B0;
                        kick_next  = 1'b1;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_B0: begin
                if (mul_done) begin
                    state_next = ST_A1;
                    kick_next  = 1'b1;
                end
            end
            ST_A1: begin
                if (mul_done) begin
                    state_next = ST_B1;
                    kick_next  = 1'b1;
                end
            end
            ST_B1: begin
                if (mul_done) begin
                    state_next = ST_H1;
                end
            end
            ST_H1: begin
                state_next = ST_A2;
                kick_next  = 1'b1;
            end
            ST_A2: begin
                if (mul_done) begin
                    state_next = ST_B2;
                    kick_next  = 1'b1;
                end
            end
            ST_B2: begin
                if (mul_done) begin
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = (m_tvalid_reg & ~m_tready) | ((state_reg == ST_OUT) & out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kick_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kick_reg     <= kick_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg <= B0_RESET;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
            enable_reg  <= 1'b0;
            active_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_B0:     coef_b0_reg <= $signed(cfg_wr_data);
                REG_B1:     coef_b1_reg <= $signed(cfg_wr_data);
                REG_B2:     coef_b2_reg <= $signed(cfg_wr_data);
                REG_A1:     coef_a1_reg <= $signed(cfg_wr_data);
                REG_A2:     coef_a2_reg <= $signed(cfg_wr_data);
                REG_ENABLE: enable_reg  <= cfg_wr_data[0];
                REG_ACTIVE: active_reg  <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_reg <= '0;
            h2_reg <= '0;
        end else begin
            if (state_reg == ST_H1) begin
                h1_reg <= alu_out;
            end
            if (state_reg == ST_B2 && mul_done) begin
                h2_reg <= alu_out;
            end
            // Clearing wins over any update in the same cycle.
            if ((s_acc && s_clear) || cfg_hit) begin
                h1_reg <= '0;
                h2_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            x_reg <= s_tdata[SAMPLE_BITS-1:0];
            if (!filter_on) begin
                res_reg     <= s_tdata[SAMPLE_BITS-1:0];
                res_sat_reg <= 1'b0;
            end
        end
        if (state_reg == ST_B0 && mul_done) begin
            y_reg <= alu_out;
        end
        if ((state_reg == ST_A1 || state_reg == ST_A2) && mul_done) begin
            tmp_reg <= mul_prod;
        end
        if (state_reg == ST_B1 && mul_done) begin
            tmp_reg <= alu_out;
        end
        if (state_reg == ST_RND) begin
            res_reg     <= rnd_val;
            res_sat_reg <= rnd_clip;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= TDATA_W'({res_sat_reg, res_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_B0 || state_reg == ST_A1 || state_reg == ST_B1
                      || state_reg == ST_A2 || state_reg == ST_B2))
        else $error("product returned outside a multiply phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (h1_reg == '0 && h2_reg == '0))
        else $error("history not cleared after register write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[SAMPLE_BITS])
            |-> (m_tdata_reg[SAMPLE_BITS-1:0] == SMAX || m_tdata_reg[SAMPLE_BITS-1:0] == SMIN))
        else $error("saturated flag set on an unclipped sample");

endmodule

FILE: tb/inverse_resonance_biquad_axis_tb.sv
// Self-checking bench for one biquad filter axis: directed and random samples against a bit-exact predictor.
module inverse_resonance_biquad_axis_tb;
    import ibq_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 48;
    localparam int FRAC_BITS   = 36;
    localparam int TDATA_W     = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN  = -(2 ** (SAMPLE_BITS - 1));
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 14;
    localparam int PHASE_ITEMS = 100;

    typedef logic signed [127:0]    wide_t;
    typedef logic [COEF_BITS-1:0]   coef_t;
    typedef logic [SAMPLE_BITS-1:0] smp_t;
    typedef struct packed {
        smp_t value;
        logic clipped;
    } axis_out_t;

    localparam coef_t COEF_TOP    = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam coef_t COEF_BOTTOM = {1'b1, {(COEF_BITS-1){1'b0}}};

    class biquad_scoreboard;
        coef_t     b0, b1, b2, a1, a2;
        logic      enable, active;
        hist_t     hist_one, hist_two;
        axis_out_t pending_outputs[$];
        int        errors;

        function new();
            b0 = coef_t'(1) << FRAC_BITS;
            b1 = '0;
            b2 = '0;
            a1 = '0;
            a2 = '0;
            enable = 1'b0;
            active = 1'b0;
            hist_one = '0;
            hist_two = '0;
            errors = 0;
        endfunction

        function hist_t clamp64(wide_t v);
            if (v > HIST_MAX) return HIST_MAX;
            if (v < HIST_MIN) return HIST_MIN;
            return v[HIST_BITS-1:0];
        endfunction

        function hist_t add_sat(hist_t a, hist_t b);
            wide_t s;
            s = a;
            s = s + b;
            return clamp64(s);
        endfunction

        function hist_t sub_sat(hist_t a, hist_t b);
            wide_t s;
            s = a;
            s = s - b;
            return clamp64(s);
        endfunction

        // Exact product, rounded half away from zero after dropping sh bits.
        function hist_t mul_scaled(hist_t a, hist_t b, int sh);
            wide_t p, wb, half;
            logic  neg;
            p = a;
            wb = b;
            p = p * wb;
            neg = p < 0;
            if (neg) p = -p;
            if (sh > 0) begin
                half = 1;
                half = half << (sh - 1);
                p = (p + half) >>> sh;
            end
            if (neg) p = -p;
            return clamp64(p);
        endfunction

        function hist_t widen(coef_t c);
            hist_t w;
            w = $signed(c);
            return w;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, coef_t data);
            case (idx)
                REG_B0:     b0 = data;
                REG_B1:     b1 = data;
                REG_B2:     b2 = data;
                REG_A1:     a1 = data;
                REG_A2:     a2 = data;
                REG_ENABLE: enable = data[0];
                REG_ACTIVE: active = data[0];
                default:    return;
            endcase
            hist_one = '0;
            hist_two = '0;
        endfunction

        function void note_sample(smp_t x_raw, logic clr);
            hist_t     x, y;
            wide_t     m, half;
            axis_out_t res;
            if (clr) begin
                hist_one = '0;
                hist_two = '0;
            end
            res.value = x_raw;
            res.clipped = 1'b0;
            if (enable && active) begin
                x = $signed(x_raw);
                y = add_sat(mul_scaled(widen(b0), x, 0), hist_one);
                hist_one = add_sat(sub_sat(mul_scaled(widen(b1), x, 0),
                                           mul_scaled(widen(a1), y, FRAC_BITS)), hist_two);
                hist_two = sub_sat(mul_scaled(widen(b2), x, 0),
                                   mul_scaled(widen(a2), y, FRAC_BITS));
                m = y;
                if (y < 0) m = -m;
                half = 1;
                half = half << (FRAC_BITS - 1);
                m = (m + half) >>> FRAC_BITS;
                if (y < 0) m = -m;
                if (m > SAMPLE_MAX) begin
                    res.value = smp_t'(SAMPLE_MAX);
                    res.clipped = 1'b1;
                end else if (m < SAMPLE_MIN) begin
                    res.value = smp_t'(SAMPLE_MIN);
                    res.clipped = 1'b1;
                end else begin
                    res.value = m[SAMPLE_BITS-1:0];
                end
            end
            pending_outputs.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [TDATA_W-1:0] data);
            axis_out_t want;
            if (pending_outputs.size() == 0) begin
                report($sformatf("result %h with no request pending", data));
                return;
            end
            want = pending_outputs.pop_front();
            if (data[SAMPLE_BITS-1:0] !== want.value)
                report($sformatf("sample_out %0d, want %0d",
                                 $signed(data[SAMPLE_BITS-1:0]), $signed(want.value)));
            if (data[SAMPLE_BITS] !== want.clipped)
                report($sformatf("saturated %b, want %b", data[SAMPLE_BITS], want.clipped));
        endtask

        task close_out();
            if (pending_outputs.size() != 0)
                report($sformatf("%0d results never arrived", pending_outputs.size()));
        endtask

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    coef_t              cfg_wr_data = '0;

    bit steady = 1'b0;
    int stall_count = 0;
    biquad_scoreboard book;

    always #2 aclk = ~aclk;

    inverse_resonance_biquad_axis #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COEF_BITS     (COEF_BITS),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data)
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tdata);
        m_tready <= steady || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("inverse_resonance_biquad_axis_tb: errors");
            $finish;
        end
    end

    task automatic program_reg(logic [CFG_ADDR_W-1:0] idx, coef_t data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        book.write_reg(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Leave valid high after acceptance; the next request or a drain decides.
    task automatic send_sample(smp_t x, logic clr);
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_W - SAMPLE_BITS - 1){1'b0}}, clr, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_sample(x, clr);
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic coef_t milli_coef(int k);
        longint v;
        v = (longint'(k) <<< FRAC_BITS) / 1000;
        return v[COEF_BITS-1:0];
    endfunction

    function automatic coef_t mild_coef();
        logic [63:0]                  raw;
        logic signed [COEF_BITS-1:0] r;
        raw = {$urandom, $urandom};
        r = raw[COEF_BITS-1:0];
        return r >>> $urandom_range(14, 10);
    endfunction

    function automatic coef_t wild_coef();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return COEF_TOP;
            1:       return COEF_BOTTOM;
            2:       return mild_coef();
            default: return raw[COEF_BITS-1:0];
        endcase
    endfunction

    // Random upper bits must be ignored by one-bit registers.
    function automatic coef_t flag_word(logic on);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return {raw[COEF_BITS-1:1], on};
    endfunction

    function automatic smp_t pick_sample();
        case ($urandom_range(19))
            0:       return smp_t'(SAMPLE_MAX);
            1:       return smp_t'(SAMPLE_MIN);
            2, 3, 4: return smp_t'($urandom_range(510)) - smp_t'(255);
            default: return smp_t'($urandom);
        endcase
    endfunction

    // Keep the poles inside the stability triangle so history stays live.
    task automatic load_stable();
        int a2k, lim;
        a2k = int'($urandom_range(1900)) - 950;
        lim = (1000 + a2k) * 95 / 100;
        program_reg(REG_B0, mild_coef());
        program_reg(REG_B1, mild_coef());
        program_reg(REG_B2, mild_coef());
        program_reg(REG_A1, milli_coef(int'($urandom_range(2 * lim)) - lim));
        program_reg(REG_A2, milli_coef(a2k));
    endtask

    task automatic run_phase(int ix);
        if (ix % 4 == 2) begin
            program_reg(REG_B0, wild_coef());
            program_reg(REG_B1, wild_coef());
            program_reg(REG_B2, wild_coef());
            program_reg(REG_A1, wild_coef());
            program_reg(REG_A2, wild_coef());
        end else begin
            load_stable();
        end
        program_reg(REG_ENABLE, flag_word(ix % 4 != 3 || $urandom_range(1)));
        program_reg(REG_ACTIVE, flag_word(ix % 4 != 3 || $urandom_range(1)));
        if (ix == 5) program_reg(REG_SPARE, flag_word(1'b0));
        steady = (ix == 6 || ix == 7);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(pick_sample(), $urandom_range(99) < 3);
            if (ix == 3 && n == PHASE_ITEMS / 2) drain_outputs();
        end
        drain_outputs();
    endtask

    initial begin
        book = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bypass out of reset, clear while bypassed
        send_sample(smp_t'(SAMPLE_MAX), 1'b0);
        send_sample(smp_t'(SAMPLE_MIN), 1'b1);
        send_sample(smp_t'(1), 1'b0);
        drain_outputs();
        program_reg(REG_ENABLE, {{(COEF_BITS-1){1'b1}}, 1'b0});
        program_reg(REG_ACTIVE, coef_t'(1));
        send_sample(smp_t'(-1), 1'b0);
        drain_outputs();

        // unity b0 from reset
        program_reg(REG_ENABLE, '1);
        send_sample(smp_t'(SAMPLE_MAX), 1'b0);
        send_sample(smp_t'(SAMPLE_MIN), 1'b0);
        send_sample(smp_t'(0), 1'b0);
        drain_outputs();

        // gain 1.5: ties round away from zero, extremes clip
        program_reg(REG_B0, coef_t'(3) << (FRAC_BITS - 1));
        send_sample(smp_t'(1), 1'b0);
        send_sample(smp_t'(-1), 1'b0);
        send_sample(smp_t'(3), 1'b0);
        send_sample(smp_t'(SAMPLE_MAX), 1'b0);
        send_sample(smp_t'(SAMPLE_MIN), 1'b0);
        drain_outputs();

        // resonant section: impulse, then ringing through history
        program_reg(REG_B0, milli_coef(1000));
        program_reg(REG_B1, milli_coef(500));
        program_reg(REG_B2, milli_coef(250));
        program_reg(REG_A1, milli_coef(-1500));
        program_reg(REG_A2, milli_coef(750));
        send_sample(smp_t'(1000), 1'b0);
        send_sample(smp_t'(0), 1'b0);
        send_sample(smp_t'(0), 1'b0);
        send_sample(smp_t'(0), 1'b0);
        drain_outputs();

        // undefined index must keep history; then clear mid-ring
        program_reg(REG_SPARE, '1);
        send_sample(smp_t'(0), 1'b0);
        send_sample(smp_t'(0), 1'b0);
        send_sample(smp_t'(0), 1'b1);
        send_sample(smp_t'(0), 1'b0);
        drain_outputs();

        // extreme coefficients drive the 64-bit intermediates into saturation
        program_reg(REG_B0, COEF_TOP);
        program_reg(REG_B1, COEF_TOP);
        program_reg(REG_B2, COEF_BOTTOM);
        program_reg(REG_A1, COEF_BOTTOM);
        program_reg(REG_A2, COEF_TOP);
        send_sample(smp_t'(SAMPLE_MAX), 1'b0);
        send_sample(smp_t'(SAMPLE_MIN), 1'b0);
        send_sample(smp_t'(SAMPLE_MAX), 1'b0);
        send_sample(smp_t'(0), 1'b0);
        drain_outputs();

        for (int ix = 0; ix < PHASES; ix++) run_phase(ix);
        steady = 1'b0;

        repeat (60) @(posedge aclk);
        book.close_out();
        if (book.errors == 0)
            $display("inverse_resonance_biquad_axis_tb: clean");
        else
            $display("inverse_resonance_biquad_axis_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/ibq_pkg.sv
rtl/ibq_mul.sv
rtl/inverse_resonance_biquad_axis.sv
tb/inverse_resonance_biquad_axis_tb.sv
